@@ hdl/wrsm_pkg.sv @@
`timescale 1ns / 1ps

package wrsm_pkg;

   // Fixed-point constants.
   localparam logic [31:0] ONE_Q = 32'd65536;
   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
   localparam logic [48:0] SAT48 = 49'h1_0000_0000_0000;

   // Divider geometry: 64-bit dividend, 32-bit divisor, one bit per step.
   localparam int DIV_STEPS = 64;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   // Operation codes.
   localparam logic [1:0] OP_MERGE  = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_LOAD   = 2'd2;

   // Status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_NEGATIVE = 2'd2;
   localparam logic [1:0] ST_ZERO_DIV = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] sample_mean;
      logic [31:0]        sample_weight;
      logic [47:0]        sample_m2;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_mean;
      logic [31:0]        new_weight;
      logic [47:0]        new_m2;
      logic [47:0]        variance_out;
      logic               variance_valid;
      logic [1:0]         status;
   } rsp_type;

   // Command to the shared divider.
   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [31:0] den;
   } div_cmd_type;

endpackage

@@ hdl/wrsm_mul.sv @@
`timescale 1ns / 1ps

module wrsm_mul (
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [63:0] p
);

   logic [63:0] p_ff;
   logic [63:0] p_in;

   // Unsigned 32x32 product, registered.
   assign p_in = 64'(a) * 64'(b);

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

@@ hdl/wrsm_div.sv @@
`timescale 1ns / 1ps

module wrsm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  wrsm_pkg::div_cmd_type cmd,
   output logic                 done,
   output logic [63:0]          quo
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [wrsm_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]                   num_ff, num_in;
   logic [31:0]                   den_ff, den_in;
   logic [31:0]                   rem_ff, rem_in;
   logic [32:0]                   rem_t;
   logic [32:0]                   rem_d;
   logic                          ge;

   // One restoring step: shift in the next dividend bit and try the subtract.
   always_comb begin
      rem_t = {rem_ff, num_ff[63]};
      ge    = rem_t >= {1'b0, den_ff};
      rem_d = rem_t - {1'b0, den_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = wrsm_pkg::DIV_CNT_W'(wrsm_pkg::DIV_STEPS);
         num_in  = cmd.num;
         den_in  = cmd.den;
         rem_in  = 32'd0;
      end else if (busy_ff) begin
         rem_in = ge ? rem_d[31:0] : rem_t[31:0];
         num_in = {num_ff[62:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == wrsm_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   // The dividend register ends up holding the quotient.
   assign done = done_ff;
   assign quo  = num_ff;

endmodule

@@ hdl/weighted_running_stats_merge.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Ports                             Word
// request   in         req_valid, req_ready, req_data    op, sample mean/weight/M2
// response  out        rsp_valid, rsp_ready, rsp_data    new state, variance, status
//
// Each word passes from accept to the next accept through three 64/32 divisions on the
// shared bit-serial divider, eleven multiply, evaluation and output steps, and an idle
// step; no new word is taken before the last one is through.
// A state weight at or below 1.0 skips the variance division.
// Reset is synchronous and clears the accumulated state to zero.
// A stalled response holds the sequencer in its last step until it is taken.

module weighted_running_stats_merge (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wrsm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wrsm_pkg::rsp_type rsp_data
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_M1   = 4'd1;
   localparam logic [3:0] S_M2   = 4'd2;
   localparam logic [3:0] S_M3   = 4'd3;
   localparam logic [3:0] S_D1S  = 4'd4;
   localparam logic [3:0] S_D1W  = 4'd5;
   localparam logic [3:0] S_D2W  = 4'd6;
   localparam logic [3:0] S_M4   = 4'd7;
   localparam logic [3:0] S_M5   = 4'd8;
   localparam logic [3:0] S_M6   = 4'd9;
   localparam logic [3:0] S_M7   = 4'd10;
   localparam logic [3:0] S_EVAL = 4'd11;
   localparam logic [3:0] S_VS   = 4'd12;
   localparam logic [3:0] S_VW   = 4'd13;
   localparam logic [3:0] S_OUT  = 4'd14;

   logic [3:0] state_ff, state_in;

   // Accumulated state.
   logic signed [31:0] acc_mean_ff, acc_mean_in;
   logic [31:0]        acc_weight_ff, acc_weight_in;
   logic [47:0]        acc_m2_ff, acc_m2_in;

   // Captured word and intermediate results.
   wrsm_pkg::req_type  req_ff, req_in;
   logic [31:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [63:0]        d2_ff, d2_in;
   logic [63:0]        numq_ff, numq_in;
   logic [63:0]        numh_ff, numh_in;
   logic [63:0]        q_ff, q_in;
   logic [63:0]        h_ff, h_in;
   logic [63:0]        p0_ff, p0_in;
   logic [63:0]        p1_ff, p1_in;
   logic [48:0]        xs_ff, xs_in;
   logic [1:0]         status_ff, status_in;
   logic [47:0]        var_ff, var_in;
   logic               vvalid_ff, vvalid_in;

   logic               rsp_valid_ff, rsp_valid_in;
   wrsm_pkg::rsp_type  rsp_ff, rsp_in;

   logic [31:0]           mul_a, mul_b;
   logic [63:0]           mul_p;
   wrsm_pkg::div_cmd_type div_cmd;
   logic                  div_done;
   logic [63:0]           div_quo;

   // Combinational helpers.
   logic signed [32:0] delta;
   logic [32:0]        w_add;
   logic [31:0]        w_sub;
   logic [31:0]        wdiv;
   logic [65:0]        xsum;
   logic               sat_hi;
   logic [50:0]        m2_add;
   logic [49:0]        take;
   logic signed [34:0] am35, q35, nm35;
   logic               accept;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   // Difference of means against the current state.
   assign delta = 33'(req_data.sample_mean) - 33'(acc_mean_ff);

   assign w_add = {1'b0, acc_weight_ff} + {1'b0, req_ff.sample_weight};
   assign w_sub = acc_weight_ff - req_ff.sample_weight;
   assign wdiv  = (req_ff.op == wrsm_pkg::OP_REMOVE) ? w_sub : w_add[31:0];

   // floor(d2*h / 2^32) from the three partial products, saturated.
   assign sat_hi = (d2_ff[63:32] != 32'd0) && (h_ff[63:32] != 32'd0);
   assign xsum   = 66'(p0_ff[63:32]) + 66'(p1_ff) + 66'(mul_p);

   assign m2_add = 51'(acc_m2_ff) + 51'(req_ff.sample_m2) + 51'(xs_ff);
   assign take   = 50'(req_ff.sample_m2) + 50'(xs_ff);
   assign am35   = 35'(acc_mean_ff);
   assign q35    = signed'(q_ff[34:0]);
   assign nm35   = (neg_ff ^ (req_ff.op == wrsm_pkg::OP_REMOVE)) ? am35 - q35 : am35 + q35;

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      case (state_ff)
         S_M1: begin
            mul_a = mag_ff;
            mul_b = mag_ff;
         end
         S_M2: begin
            mul_a = req_ff.sample_weight;
            mul_b = mag_ff;
         end
         S_M3: begin
            mul_a = acc_weight_ff;
            mul_b = req_ff.sample_weight;
         end
         S_M4: begin
            mul_a = d2_ff[31:0];
            mul_b = h_ff[31:0];
         end
         S_M5: begin
            mul_a = d2_ff[63:32];
            mul_b = h_ff[31:0];
         end
         S_M6: begin
            mul_a = d2_ff[31:0];
            mul_b = h_ff[63:32];
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   wrsm_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   wrsm_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      acc_mean_in   = acc_mean_ff;
      acc_weight_in = acc_weight_ff;
      acc_m2_in     = acc_m2_ff;
      req_in        = req_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      d2_in         = d2_ff;
      numq_in       = numq_ff;
      numh_in       = numh_ff;
      q_in          = q_ff;
      h_in          = h_ff;
      p0_in         = p0_ff;
      p1_in         = p1_ff;
      xs_in         = xs_ff;
      status_in     = status_ff;
      var_in        = var_ff;
      vvalid_in     = vvalid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      div_cmd.start = 1'b0;
      div_cmd.num   = numq_ff;
      div_cmd.den   = wdiv;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               neg_in   = delta[32];
               mag_in   = delta[32] ? 32'(-delta) : delta[31:0];
               state_in = S_M1;
            end
         end
         S_M1: state_in = S_M2;
         S_M2: begin
            d2_in    = mul_p;
            state_in = S_M3;
         end
         S_M3: begin
            numq_in  = mul_p;
            state_in = S_D1S;
         end
         S_D1S: begin
            numh_in       = mul_p;
            div_cmd.start = 1'b1;
            state_in      = S_D1W;
         end
         S_D1W: begin
            if (div_done) begin
               q_in          = div_quo;
               div_cmd.start = 1'b1;
               div_cmd.num   = numh_ff;
               state_in      = S_D2W;
            end
         end
         S_D2W: begin
            if (div_done) begin
               h_in     = div_quo;
               state_in = S_M4;
            end
         end
         S_M4: state_in = S_M5;
         S_M5: begin
            p0_in    = mul_p;
            state_in = S_M6;
         end
         S_M6: begin
            p1_in    = mul_p;
            state_in = S_M7;
         end
         S_M7: begin
            xs_in    = (sat_hi || xsum > 66'(wrsm_pkg::SAT48)) ? wrsm_pkg::SAT48 : xsum[48:0];
            state_in = S_EVAL;
         end
         S_EVAL: begin
            // Status checks in priority order, then commit on success.
            status_in = wrsm_pkg::ST_OK;
            case (req_ff.op)
               wrsm_pkg::OP_MERGE: begin
                  if (w_add == 33'd0) begin
                     status_in = wrsm_pkg::ST_ZERO_DIV;
                  end else if (w_add[32] || m2_add > 51'(wrsm_pkg::MAX48)) begin
                     status_in = wrsm_pkg::ST_NEGATIVE;
                  end else begin
                     acc_mean_in   = nm35[31:0];
                     acc_weight_in = w_add[31:0];
                     acc_m2_in     = m2_add[47:0];
                  end
               end
               wrsm_pkg::OP_REMOVE: begin
                  if (acc_weight_ff == 32'd0 || acc_weight_ff == req_ff.sample_weight) begin
                     status_in = wrsm_pkg::ST_ZERO_DIV;
                  end else if (req_ff.sample_weight > acc_weight_ff
                               || q_ff[63:33] != 31'd0
                               || nm35[34:31] != {4{nm35[31]}}
                               || take > 50'(acc_m2_ff)) begin
                     status_in = wrsm_pkg::ST_NEGATIVE;
                  end else begin
                     acc_mean_in   = nm35[31:0];
                     acc_weight_in = w_sub;
                     acc_m2_in     = acc_m2_ff - take[47:0];
                  end
               end
               wrsm_pkg::OP_LOAD: begin
                  acc_mean_in   = req_ff.sample_mean;
                  acc_weight_in = req_ff.sample_weight;
                  acc_m2_in     = req_ff.sample_m2;
               end
               default: status_in = wrsm_pkg::ST_INVALID;
            endcase
            state_in = S_VS;
         end
         S_VS: begin
            if (acc_weight_ff > wrsm_pkg::ONE_Q) begin
               div_cmd.start = 1'b1;
               div_cmd.num   = {acc_m2_ff, 16'd0};
               div_cmd.den   = acc_weight_ff - wrsm_pkg::ONE_Q;
               vvalid_in     = (acc_m2_ff != 48'd0);
               state_in      = S_VW;
            end else begin
               var_in    = 48'd0;
               vvalid_in = 1'b0;
               state_in  = S_OUT;
            end
         end
         S_VW: begin
            if (div_done) begin
               var_in   = (div_quo > 64'(wrsm_pkg::MAX48)) ? wrsm_pkg::MAX48 : div_quo[47:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // Wait for the response register to free up.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.new_mean       = acc_mean_ff;
               rsp_in.new_weight     = acc_weight_ff;
               rsp_in.new_m2         = acc_m2_ff;
               rsp_in.variance_out   = var_ff;
               rsp_in.variance_valid = vvalid_ff;
               rsp_in.status         = status_ff;
               state_in              = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         acc_mean_ff   <= '0;
         acc_weight_ff <= '0;
         acc_m2_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         acc_mean_ff   <= acc_mean_in;
         acc_weight_ff <= acc_weight_in;
         acc_m2_ff     <= acc_m2_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      d2_ff     <= d2_in;
      numq_ff   <= numq_in;
      numh_ff   <= numh_in;
      q_ff      <= q_in;
      h_ff      <= h_in;
      p0_ff     <= p0_in;
      p1_ff     <= p1_in;
      xs_ff     <= xs_in;
      status_ff <= status_in;
      var_ff    <= var_in;
      vvalid_ff <= vvalid_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hdl/wrsm_checker.sv @@
`timescale 1ns / 1ps

module wrsm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input wrsm_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input wrsm_pkg::rsp_type rsp_data
);

   // A pending response word is held, unchanged, until taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed before it was taken");

   // A waiting request word stays valid and unchanged until taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request dropped or changed before it was taken");

   // The block works on one word at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // A valid variance needs a weight above one and a nonzero M2.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.variance_valid |->
         rsp_data.new_weight > wrsm_pkg::ONE_Q && rsp_data.new_m2 != 48'd0)
      else $error("variance flagged valid on an undefined state");

   // An undefined variance reads as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.new_weight <= wrsm_pkg::ONE_Q |->
         rsp_data.variance_out == 48'd0 && !rsp_data.variance_valid)
      else $error("variance nonzero for weight at or below one");

endmodule

bind weighted_running_stats_merge wrsm_checker u_wrsm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
